@@ rtl/core/i2cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types, phase codes and helpers for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int WAIT_W = 16;  // segment counter width, 8..32
  localparam logic [31:0] WAIT_MAX = 32'hFFFF_FFFF >> (32 - WAIT_W);

  localparam logic [7:0] MSB_MASK = 8'h80;

  // command codes
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;

  // bit engine phases
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST_A  = 5'd1;
  localparam logic [4:0] PH_ST_B  = 5'd2;
  localparam logic [4:0] PH_ST_C  = 5'd3;
  localparam logic [4:0] PH_ST_D  = 5'd4;
  localparam logic [4:0] PH_SP_A  = 5'd5;
  localparam logic [4:0] PH_SP_B  = 5'd6;
  localparam logic [4:0] PH_WR_LO = 5'd7;
  localparam logic [4:0] PH_WR_HI = 5'd8;
  localparam logic [4:0] PH_WA_LO = 5'd9;
  localparam logic [4:0] PH_WA_HI = 5'd10;
  localparam logic [4:0] PH_RD_LO = 5'd11;
  localparam logic [4:0] PH_RD_HI = 5'd12;
  localparam logic [4:0] PH_RK_LO = 5'd13;
  localparam logic [4:0] PH_RK_HI = 5'd14;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } i2cbe_cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } i2cbe_res_t;

  // segment reload value: half_period - 1, zero acts as one, saturated
  function automatic logic [WAIT_W-1:0] seg_load(input logic [15:0] hp);
    logic [15:0] v;
    logic [31:0] v32;
    v   = (hp == 16'd0) ? 16'd0 : hp - 16'd1;
    v32 = {16'd0, v};
    if (v32 > WAIT_MAX) return WAIT_MAX[WAIT_W-1:0];
    return v32[WAIT_W-1:0];
  endfunction

endpackage

@@ rtl/core/i2cbe_if.sv @@
// ----------------------------------------------------------------------------
// i2cbe_in_if / i2cbe_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, mode, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, mode, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, output ready);
endinterface

@@ rtl/core/i2cbe_fsm.sv @@
// ----------------------------------------------------------------------------
// i2cbe_fsm
// Bit engine state and per-tick next-state logic; advances on step_en.
// ----------------------------------------------------------------------------
module i2cbe_fsm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  i2cbe_pkg::i2cbe_cmd_t  cmd,
  input  logic [15:0]            half_period,
  output i2cbe_pkg::i2cbe_res_t  res
);
  import i2cbe_pkg::*;

  logic [4:0]        phase_r,     phase_nxt;
  logic [3:0]        bit_cnt_r,   bit_cnt_nxt;
  logic [7:0]        shift_r,     shift_nxt;
  logic [WAIT_W-1:0] wait_r,      wait_nxt;
  logic              scl_r,       scl_nxt;
  logic              sda_r,       sda_nxt;
  logic              ack_flag_r,  ack_flag_nxt;
  logic              ack_req_r,   ack_req_nxt;
  logic [7:0]        rx_hold_r,   rx_hold_nxt;

  logic       ent;
  logic [4:0] ent_ph;
  logic       done;
  logic       rej;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    wait_nxt     = wait_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_flag_nxt = ack_flag_r;
    ack_req_nxt  = ack_req_r;
    rx_hold_nxt  = rx_hold_r;
    ent          = 1'b0;
    ent_ph       = PH_IDLE;
    done         = 1'b0;
    rej          = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (cmd.mode)
        MODE_START: begin
          ent = 1'b1; ent_ph = PH_ST_A;
        end
        MODE_WRITE: begin
          shift_nxt = cmd.tx_byte; bit_cnt_nxt = 4'd0;
          ent = 1'b1; ent_ph = PH_WR_LO;
        end
        MODE_READ: begin
          shift_nxt = 8'd0; bit_cnt_nxt = 4'd0; ack_req_nxt = cmd.send_ack;
          ent = 1'b1; ent_ph = PH_RD_LO;
        end
        MODE_STOP: begin
          ent = 1'b1; ent_ph = PH_SP_A;
        end
        default: ;
      endcase
    end else begin
      rej = cmd.mode inside {[MODE_START:MODE_STOP]};
      if (wait_r != '0) begin
        wait_nxt = wait_r - 1'b1;
      end else begin
        case (phase_r)
          PH_ST_A: begin ent = 1'b1; ent_ph = PH_ST_B; end
          PH_ST_B: begin ent = 1'b1; ent_ph = PH_ST_C; end
          PH_ST_C: begin ent = 1'b1; ent_ph = PH_ST_D; end
          PH_ST_D: begin phase_nxt = PH_IDLE; done = 1'b1; end
          PH_SP_A: begin ent = 1'b1; ent_ph = PH_SP_B; end
          PH_SP_B: begin
            sda_nxt = 1'b1; phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_WR_LO: begin ent = 1'b1; ent_ph = PH_WR_HI; end
          PH_WR_HI: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            ent         = 1'b1;
            ent_ph      = (bit_cnt_nxt >= 4'd8) ? PH_WA_LO : PH_WR_LO;
          end
          PH_WA_LO: begin ent = 1'b1; ent_ph = PH_WA_HI; end
          PH_WA_HI: begin
            ack_flag_nxt = ~cmd.sda_in;
            scl_nxt      = 1'b0;
            phase_nxt    = PH_IDLE;
            done         = 1'b1;
          end
          PH_RD_LO: begin ent = 1'b1; ent_ph = PH_RD_HI; end
          PH_RD_HI: begin
            shift_nxt   = {shift_r[6:0], cmd.sda_in};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            ent         = 1'b1;
            ent_ph      = (bit_cnt_nxt >= 4'd8) ? PH_RK_LO : PH_RD_LO;
          end
          PH_RK_LO: begin ent = 1'b1; ent_ph = PH_RK_HI; end
          PH_RK_HI: begin
            sda_nxt     = 1'b0;
            scl_nxt     = 1'b0;
            rx_hold_nxt = shift_r;
            phase_nxt   = PH_IDLE;
            done        = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // segment entry: reload the delay and apply the segment's drives
    if (ent) begin
      phase_nxt = ent_ph;
      wait_nxt  = seg_load(half_period);
      case (ent_ph)
        PH_ST_A:  sda_nxt = 1'b1;
        PH_ST_B:  scl_nxt = 1'b1;
        PH_ST_C:  sda_nxt = 1'b0;
        PH_ST_D:  scl_nxt = 1'b0;
        PH_SP_A:  begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_WR_LO: begin scl_nxt = 1'b0; sda_nxt = |(shift_nxt & MSB_MASK); end
        PH_WA_LO: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_RD_LO: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_RK_LO: begin scl_nxt = 1'b0; sda_nxt = ~ack_req_nxt; end
        PH_SP_B, PH_WR_HI, PH_WA_HI, PH_RD_HI, PH_RK_HI: scl_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      wait_r     <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_flag_r <= 1'b0;
      ack_req_r  <= 1'b0;
      rx_hold_r  <= 8'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      wait_r     <= wait_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_flag_r <= ack_flag_nxt;
      ack_req_r  <= ack_req_nxt;
      rx_hold_r  <= rx_hold_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_hold_nxt;
    res.ack_seen  = ack_flag_nxt;
    res.rejected  = rej;
  end

`ifndef ASSERT_OFF
  a_bitcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter beyond eight");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && rej) |-> (phase_r != PH_IDLE))
    else $error("reject flagged while idle");

  a_start_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r == PH_IDLE && cmd.mode == MODE_START) |=> (phase_r == PH_ST_A))
    else $error("start command did not enter first segment");

  a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r != PH_IDLE && wait_r != '0) |=> (phase_r == $past(phase_r)))
    else $error("phase moved before its delay ran out");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (phase_r == PH_IDLE))
    else $error("done pulse without return to idle");
`endif

endmodule

@@ rtl/core/i2c_master_bit_engine_core.sv @@
// Two register stages (input, then result); a result beat is registered once
// its command beat is in the input stage and the result stage is free.
// One beat per cycle unless out_ch.ready stalls; each beat is one engine tick.
// Reset (rst_n, synchronous): engine idle, SCL/SDA released, half_period = 4.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Open-drain I2C master bit engine with valid/ready tick and result channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  i2cbe_in_if.sink            in_ch,
  i2cbe_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import i2cbe_pkg::*;

  logic        in_v_r;
  i2cbe_cmd_t  in_item_r;
  logic        out_v_r;
  i2cbe_res_t  out_item_r;
  logic [15:0] half_period_r;
  logic        adv;
  logic        in_acc;
  i2cbe_res_t  res;

  assign adv          = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      half_period_r <= HALF_PERIOD_RST;
    end else begin
      if (cfg_we) half_period_r <= cfg_wdata;
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.mode     <= in_ch.mode;
      in_item_r.tx_byte  <= in_ch.tx_byte;
      in_item_r.send_ack <= in_ch.send_ack;
      in_item_r.sda_in   <= in_ch.sda_in;
    end
    if (adv) out_item_r <= res;
  end

  i2cbe_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .cmd         (in_item_r),
    .half_period (half_period_r),
    .res         (res)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.scl_level = out_item_r.scl_level;
  assign out_ch.sda_level = out_item_r.sda_level;
  assign out_ch.busy_res  = out_item_r.busy_res;
  assign out_ch.done_res  = out_item_r.done_res;
  assign out_ch.rx_byte   = out_item_r.rx_byte;
  assign out_ch.ack_seen  = out_item_r.ack_seen;
  assign out_ch.rejected  = out_item_r.rejected;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Tick-level check of the I2C master bit engine. Every accepted command beat
// advances an engine model kept in a scoreboard. Each result beat is compared
// field by field against the model's line drives and flags. Stimulus: directed
// commands, then random start/write/read/stop transfers with noise, across
// several half-period settings including zero.
// ----------------------------------------------------------------------------
module testbench;
  import i2cbe_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_TICKS = 1350;
  localparam int PHASE_TICKS  = 300;
  localparam int SDA_LOW      = 0;
  localparam int SDA_HIGH     = 1;
  localparam int SDA_RANDOM   = 2;

  class bit_engine_scoreboard;
    logic [15:0]       half_period;
    logic [4:0]        stage;
    logic [3:0]        bit_cnt;
    logic [7:0]        shreg;
    logic [WAIT_W-1:0] wait_cnt;
    logic              scl_drv;
    logic              sda_drv;
    logic              ack_flag;
    logic              ack_req;
    logic [7:0]        rx_hold;
    i2cbe_res_t        expected_drive_q[$];
    int                n_err;
    int                n_ticks;
    int                n_checked;
    int                n_done;
    int                n_rej;

    function new();
      half_period = HALF_PERIOD_RST;
      stage       = PH_IDLE;
      bit_cnt     = '0;
      shreg       = '0;
      wait_cnt    = '0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      ack_flag    = 1'b0;
      ack_req     = 1'b0;
      rx_hold     = '0;
      n_err       = 0;
      n_ticks     = 0;
      n_checked   = 0;
      n_done      = 0;
      n_rej       = 0;
    endfunction

    // ticks left in a segment after the entry tick; zero acts as one
    function logic [WAIT_W-1:0] segment_reload();
      logic [31:0] v;
      v = (half_period == 16'd0) ? 32'd0 : {16'd0, half_period} - 32'd1;
      if (v > WAIT_MAX) v = WAIT_MAX;
      return v[WAIT_W-1:0];
    endfunction

    function void load_stage(logic [4:0] nxt);
      stage    = nxt;
      wait_cnt = segment_reload();
      case (nxt)
        PH_ST_A:  sda_drv = 1'b1;
        PH_ST_B:  scl_drv = 1'b1;
        PH_ST_C:  sda_drv = 1'b0;
        PH_ST_D:  scl_drv = 1'b0;
        PH_SP_A: begin
          scl_drv = 1'b0;
          sda_drv = 1'b0;
        end
        PH_WR_LO: begin
          scl_drv = 1'b0;
          sda_drv = ((shreg & MSB_MASK) != 8'd0);
        end
        PH_WA_LO, PH_RD_LO: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
        end
        PH_RK_LO: begin
          scl_drv = 1'b0;
          sda_drv = ~ack_req;
        end
        PH_SP_B, PH_WR_HI, PH_WA_HI, PH_RD_HI, PH_RK_HI: scl_drv = 1'b1;
        default: ;
      endcase
    endfunction

    function void take_tick(i2cbe_cmd_t c);
      logic       is_cmd;
      logic       done;
      logic       rej;
      i2cbe_res_t r;
      is_cmd = (c.mode >= MODE_START) && (c.mode <= MODE_STOP);
      done   = 1'b0;
      rej    = 1'b0;
      n_ticks++;
      if (stage == PH_IDLE) begin
        case (c.mode)
          MODE_START: load_stage(PH_ST_A);
          MODE_WRITE: begin
            shreg   = c.tx_byte;
            bit_cnt = '0;
            load_stage(PH_WR_LO);
          end
          MODE_READ: begin
            shreg   = '0;
            bit_cnt = '0;
            ack_req = c.send_ack;
            load_stage(PH_RD_LO);
          end
          MODE_STOP: load_stage(PH_SP_A);
          default: ;
        endcase
      end else begin
        rej = is_cmd;
        if (wait_cnt != '0) begin
          wait_cnt--;
        end else begin
          case (stage)
            PH_ST_A: load_stage(PH_ST_B);
            PH_ST_B: load_stage(PH_ST_C);
            PH_ST_C: load_stage(PH_ST_D);
            PH_ST_D: begin
              stage = PH_IDLE;
              done  = 1'b1;
            end
            PH_SP_A: load_stage(PH_SP_B);
            PH_SP_B: begin
              sda_drv = 1'b1;
              stage   = PH_IDLE;
              done    = 1'b1;
            end
            PH_WR_LO: load_stage(PH_WR_HI);
            PH_WR_HI: begin
              shreg   = shreg << 1;
              bit_cnt = bit_cnt + 4'd1;
              load_stage((bit_cnt >= 4'd8) ? PH_WA_LO : PH_WR_LO);
            end
            PH_WA_LO: load_stage(PH_WA_HI);
            PH_WA_HI: begin
              ack_flag = ~c.sda_in;
              scl_drv  = 1'b0;
              stage    = PH_IDLE;
              done     = 1'b1;
            end
            PH_RD_LO: load_stage(PH_RD_HI);
            PH_RD_HI: begin
              shreg   = {shreg[6:0], c.sda_in};
              bit_cnt = bit_cnt + 4'd1;
              load_stage((bit_cnt >= 4'd8) ? PH_RK_LO : PH_RD_LO);
            end
            PH_RK_LO: load_stage(PH_RK_HI);
            PH_RK_HI: begin
              sda_drv = 1'b0;
              scl_drv = 1'b0;
              rx_hold = shreg;
              stage   = PH_IDLE;
              done    = 1'b1;
            end
            default: stage = PH_IDLE;  // stray code: back to idle, no done
          endcase
        end
      end
      if (done) n_done++;
      if (rej) n_rej++;
      r.scl_level = scl_drv;
      r.sda_level = sda_drv;
      r.busy_res  = (stage != PH_IDLE);
      r.done_res  = done;
      r.rx_byte   = rx_hold;
      r.ack_seen  = ack_flag;
      r.rejected  = rej;
      expected_drive_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_err++;
        if (n_err <= 30)
          $display("%0t: %s mismatch at result %0d: expected %0h, actual %0h",
                   $time, name, n_checked, want, got);
      end
    endfunction

    function void check_drive(i2cbe_res_t got);
      i2cbe_res_t want;
      if (expected_drive_q.size() == 0) begin
        n_err++;
        if (n_err <= 30)
          $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
        return;
      end
      want = expected_drive_q.pop_front();
      n_checked++;
      compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
      compare_field("done_res",  8'(want.done_res),  8'(got.done_res));
      compare_field("rx_byte",   want.rx_byte,       got.rx_byte);
      compare_field("ack_seen",  8'(want.ack_seen),  8'(got.ack_seen));
      compare_field("rejected",  8'(want.rejected),  8'(got.rejected));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  i2cbe_in_if  in_ch();
  i2cbe_out_if out_ch();

  i2c_master_bit_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bit_engine_scoreboard sb = new();

  bit          tx_idle_en;
  bit          rx_idle_en;
  int          hold_cycles;
  int          cycle_count;
  i2cbe_cmd_t  seen_tick;
  i2cbe_res_t  seen_drive;
  logic [15:0] hp_steps [0:6] = '{16'd2, 16'd1, 16'd3, 16'd0, 16'd5, 16'd1, 16'd2};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_tick.mode     = in_ch.mode;
      seen_tick.tx_byte  = in_ch.tx_byte;
      seen_tick.send_ack = in_ch.send_ack;
      seen_tick.sda_in   = in_ch.sda_in;
      sb.take_tick(seen_tick);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_drive.scl_level = out_ch.scl_level;
      seen_drive.sda_level = out_ch.sda_level;
      seen_drive.busy_res  = out_ch.busy_res;
      seen_drive.done_res  = out_ch.done_res;
      seen_drive.rx_byte   = out_ch.rx_byte;
      seen_drive.ack_seen  = out_ch.ack_seen;
      seen_drive.rejected  = out_ch.rejected;
      sb.check_drive(seen_drive);
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  function automatic logic pick_sda(int sel);
    if (sel == SDA_LOW) return 1'b0;
    if (sel == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // one engine tick; called at a falling edge, returns at one with valid held
  task automatic send_tick(input logic [2:0] m, input logic [7:0] tx, input logic ak,
                           input logic sd);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.mode     = m;
    in_ch.tx_byte  = tx;
    in_ch.send_ack = ak;
    in_ch.sda_in   = sd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // issue a command, then tick until the engine is idle again; filler ticks
  // carry a stray command with the given percent chance
  task automatic run_cmd(input logic [2:0] m, input logic [7:0] tx, input logic ak,
                         input int sda_sel, input int noise_pct);
    logic [2:0] fm;
    send_tick(m, tx, ak, pick_sda(sda_sel));
    while (sb.stage != PH_IDLE) begin
      fm = ($urandom_range(1, 100) <= noise_pct) ? 3'($urandom_range(1, 7)) : MODE_NONE;
      send_tick(fm, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                pick_sda(sda_sel));
    end
    repeat ($urandom_range(0, 2))
      send_tick(MODE_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                pick_sda(SDA_RANDOM));
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.expected_drive_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_half_period(input logic [15:0] hp);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = hp;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.half_period = hp;
  endtask

  task automatic random_transfer();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      // broken sequence: lone command of any code
      run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), SDA_RANDOM, 6);
      return;
    end
    run_cmd(MODE_START, 8'd0, 1'b0, SDA_RANDOM, 6);
    run_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 6);
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 1))
        run_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 6);
      else
        run_cmd(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                SDA_RANDOM, 6);
    end
    if ($urandom_range(0, 7) != 0)
      run_cmd(MODE_STOP, 8'd0, 1'b0, SDA_RANDOM, 6);
  endtask

  initial begin
    int base;
    int phase_start;
    int k;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_NONE;
    in_ch.tx_byte  = '0;
    in_ch.send_ack = 1'b0;
    in_ch.sda_in   = 1'b0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_cycles    = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // unused codes while idle, then a start at the reset half period with
    // stray commands on every busy tick, the finishing tick included
    send_tick(3'd5, 8'hFF, 1'b1, 1'b1);
    send_tick(3'd6, 8'h00, 1'b0, 1'b0);
    send_tick(3'd7, 8'h5A, 1'b1, 1'b0);
    run_cmd(MODE_START, 8'd0, 1'b0, SDA_RANDOM, 100);

    set_half_period(16'd1);
    run_cmd(MODE_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);   // slave acks
    run_cmd(MODE_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);  // slave nacks
    run_cmd(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 0);
    run_cmd(MODE_READ, 8'h00, 1'b1, SDA_HIGH, 0);
    run_cmd(MODE_READ, 8'hFF, 1'b0, SDA_LOW, 0);
    run_cmd(MODE_STOP, 8'd0, 1'b0, SDA_RANDOM, 100);

    // zero half period behaves as one
    set_half_period(16'd0);
    run_cmd(MODE_START, 8'd0, 1'b0, SDA_RANDOM, 0);
    run_cmd(MODE_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 0);
    run_cmd(MODE_READ, 8'h00, 1'b1, SDA_RANDOM, 0);
    run_cmd(MODE_STOP, 8'd0, 1'b0, SDA_RANDOM, 0);

    base = sb.n_ticks;
    k = 0;
    while (sb.n_ticks - base < RANDOM_TICKS) begin
      set_half_period(hp_steps[k % 7]);
      tx_idle_en = (k % 3 != 2);
      rx_idle_en = (k % 4 != 3);
      if (k == 2) hold_cycles = 150;  // receiver backs up, input must stall
      phase_start = sb.n_ticks;
      while (sb.n_ticks - phase_start < PHASE_TICKS) random_transfer();
      k++;
    end

    // longer segments: one stop at a wider half period, no idling
    set_half_period(16'd20);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_cmd(MODE_STOP, 8'd0, 1'b0, SDA_RANDOM, 0);

    drain();
    $display("covered %0d engine ticks, %0d result beats checked, %0d commands done,",
             sb.n_ticks, sb.n_checked, sb.n_done);
    $display("%0d busy rejections; directed half periods 4, 1, 0 and 20, random ones"
             , sb.n_rej);
    $display("over small settings with stalls; %0d errors", sb.n_err);
    if (sb.n_err == 0 && sb.expected_drive_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ i2c_master_bit_engine_core.f @@
rtl/core/i2cbe_pkg.sv
rtl/core/i2cbe_if.sv
rtl/core/i2cbe_fsm.sv
rtl/core/i2c_master_bit_engine_core.sv
test/testbench.sv
